[sv/dcpa_pkg.sv]
package dcpa_pkg;

    // sample and window sizes
    localparam int ADC_BITS   = 12;
    localparam int MAX_WINDOW = 255;
    localparam int WIN_W      = 8;

    // datapath widths
    localparam int C_W     = ADC_BITS + 1;
    localparam int SQ_W    = 32;
    localparam int PS_W    = 33;
    localparam int LIN_W   = 21;
    localparam int FILT_W  = 38;
    localparam int ALPHA_W = 16;
    localparam int FRAC_W  = 16;

    // shared multiplier operand and product widths
    localparam int MUL_XW = 22;
    localparam int MUL_YW = 18;
    localparam int PROD_W = MUL_XW + MUL_YW;

    // filter state is multiplied in two halves
    localparam int HALF_W = FILT_W / 2;
    localparam int PART_W = 56;

    // bias correction quotient width
    localparam int DIV_W = FILT_W - 1 - FRAC_W;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASELINE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SINGLE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA    = 2'd3;

    // input commands
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;
    localparam logic [1:0] CMD_RSVD   = 2'd3;

    // reset values
    localparam logic [WIN_W-1:0]    WINDOW_RST = WIN_W'(64);
    localparam logic [ALPHA_W-1:0]  ALPHA_RST  = ALPHA_W'(6554);
    localparam logic [ADC_BITS-1:0] BIAS_MID   = ADC_BITS'(1 << (ADC_BITS - 1));
    localparam logic [ADC_BITS-1:0] ADC_MAX    = '1;

    // window length with zero and over-range values pulled into range
    function automatic logic [WIN_W-1:0] eff_len(input logic [WIN_W-1:0] wl);
        logic [WIN_W:0] lim;
        lim = (WIN_W + 1)'(MAX_WINDOW);
        if (wl == '0) begin
            return WIN_W'(1);
        end else if ({1'b0, wl} > lim) begin
            return lim[WIN_W-1:0];
        end else begin
            return wl;
        end
    endfunction

endpackage

[sv/dcpa_mul.sv]
module dcpa_mul (
    input  logic                                i_clk,
    input  logic                                i_start,
    input  logic signed [dcpa_pkg::MUL_XW-1:0] i_x,
    input  logic signed [dcpa_pkg::MUL_YW-1:0] i_y,
    output logic signed [dcpa_pkg::PROD_W-1:0] o_prod
);
    import dcpa_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // one signed product per issue, held until the next issue
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= PROD_W'(i_x) * PROD_W'(i_y);
        end
    end

    assign o_prod = r_prod;

endmodule

[sv/dcpa_div.sv]
module dcpa_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dcpa_pkg::DIV_W-1:0]    i_dividend,
    input  logic [dcpa_pkg::WIN_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [dcpa_pkg::DIV_W-1:0]    o_quotient
);
    import dcpa_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_quo;
    logic [WIN_W-1:0] r_rem;
    logic [WIN_W-1:0] r_div;

    logic [WIN_W:0]   n_trial;
    logic             n_fit;
    logic [WIN_W:0]   n_rem;

    // restoring step: one quotient bit per cycle
    always_comb begin
        n_trial = {r_rem, r_quo[DIV_W-1]};
        n_fit   = (n_trial >= {1'b0, r_div});
        n_rem   = n_fit ? (n_trial - {1'b0, r_div}) : n_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[DIV_W-2:0], n_fit};
                r_rem <= n_rem[WIN_W-1:0];
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

[sv/dual_channel_power_accumulator.sv]
// channel | direction | handshake                 | payload
// input   | in        | i_in_valid / o_in_stall   | i_command, i_sample_a, i_sample_b
// output  | out       | o_out_valid / i_out_stall | sums, biases, o_scan_done
// config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// start, stop, reserved commands and pairs taken while idle leave the input open.
// a sample pair inside a window makes three passes through the shared multiplier.
// the pair that closes a window then goes to the output step; with baseline restoration on,
// per channel it first takes multiplier passes and rounding, the serial divider, then the bias step.
// reset is synchronous: registers at reset values, biases at mid-scale, not acquiring.
// a result waits in the output register; input is still taken while it is stalled, but the next result waits.
module dual_channel_power_accumulator (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [1:0]                            i_command,
    input  logic [dcpa_pkg::ADC_BITS-1:0]         i_sample_a,
    input  logic [dcpa_pkg::ADC_BITS-1:0]         i_sample_b,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [dcpa_pkg::SQ_W-1:0]             o_sum_sq_a,
    output logic [dcpa_pkg::SQ_W-1:0]             o_sum_sq_b,
    output logic signed [dcpa_pkg::PS_W-1:0]      o_sum_product,
    output logic [dcpa_pkg::ADC_BITS-1:0]         o_bias_a_out,
    output logic [dcpa_pkg::ADC_BITS-1:0]         o_bias_b_out,
    output logic                                  o_scan_done,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [dcpa_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [dcpa_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import dcpa_pkg::*;

    localparam int BV_W  = DIV_W + 2;
    localparam int RND_W = PART_W - FRAC_W;
    localparam logic [PART_W-1:0] RND_UP = PART_W'(1) << (FRAC_W - 1);
    localparam logic [PART_W-1:0] RND_DN = RND_UP - PART_W'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_MA, S_MB, S_MP, S_ACC,
        S_F0, S_F1, S_F2, S_F3, S_F4, S_F5, S_DIV, S_BIAS, S_OUT
    } t_state;

    t_state r_state;

    // configuration
    logic [WIN_W-1:0]   r_window;
    logic               r_base;
    logic               r_single;
    logic [ALPHA_W-1:0] r_alpha;

    // window and tracking state
    logic                     r_acq;
    logic [WIN_W-1:0]         r_count;
    logic [SQ_W-1:0]          r_sq_a;
    logic [SQ_W-1:0]          r_sq_b;
    logic signed [PS_W-1:0]   r_ps;
    logic signed [LIN_W-1:0]  r_lin_a;
    logic signed [LIN_W-1:0]  r_lin_b;
    logic signed [FILT_W-1:0] r_filt_a;
    logic signed [FILT_W-1:0] r_filt_b;
    logic [ADC_BITS-1:0]      r_bias_a;
    logic [ADC_BITS-1:0]      r_bias_b;
    logic                     r_ch;

    // working registers
    logic signed [C_W-1:0]    r_ca;
    logic signed [C_W-1:0]    r_cb;
    logic signed [PART_W-1:0] r_p;
    logic signed [RND_W-1:0]  r_rnd;

    // output word
    logic                     r_out_valid;
    logic [SQ_W-1:0]          r_out_sq_a;
    logic [SQ_W-1:0]          r_out_sq_b;
    logic signed [PS_W-1:0]   r_out_ps;
    logic [ADC_BITS-1:0]      r_out_bias_a;
    logic [ADC_BITS-1:0]      r_out_bias_b;
    logic                     r_out_done;

    // shared units
    logic                      mul_start;
    logic signed [MUL_XW-1:0]  mul_x;
    logic signed [MUL_YW-1:0]  mul_y;
    logic signed [PROD_W-1:0]  mul_prod;
    logic                      div_start;
    logic                      div_done;
    logic [DIV_W-1:0]          div_q;

    // combinational next values
    logic                     accept;
    logic [WIN_W-1:0]         n_len;
    logic signed [C_W-1:0]    n_ca;
    logic signed [C_W-1:0]    n_cb;
    logic signed [LIN_W:0]    n_lin_sum_a;
    logic signed [LIN_W:0]    n_lin_sum_b;
    logic signed [LIN_W-1:0]  n_lin_a;
    logic signed [LIN_W-1:0]  n_lin_b;
    logic [SQ_W:0]            n_sq_sum;
    logic [SQ_W-1:0]          n_sq;
    logic signed [PS_W:0]     n_ps_sum;
    logic signed [PS_W-1:0]   n_ps;
    logic [WIN_W:0]           n_cnt;
    logic                     n_last;
    logic signed [FILT_W-1:0] filt_sel;
    logic signed [LIN_W-1:0]  lin_sel;
    logic [ADC_BITS-1:0]      bias_sel;
    logic [ALPHA_W:0]         n_w;
    logic [PART_W-1:0]        n_rnd_sum;
    logic signed [PROD_W:0]   n_f;
    logic [FILT_W-1:0]        n_k;
    logic [FILT_W-1:0]        n_x;
    logic signed [BV_W-1:0]   n_bb;
    logic signed [BV_W-1:0]   n_bq;
    logic signed [BV_W-1:0]   n_bv;
    logic [ADC_BITS-1:0]      n_bias;

    assign accept      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // centring and linear sums for the incoming pair
    always_comb begin
        n_len = eff_len(r_window);
        if (r_base) begin
            n_ca = signed'({1'b0, i_sample_a}) - signed'({1'b0, r_bias_a});
            n_cb = signed'({1'b0, i_sample_b}) - signed'({1'b0, r_bias_b});
        end else begin
            n_ca = signed'({1'b0, i_sample_a});
            n_cb = signed'({1'b0, i_sample_b});
        end
        n_lin_sum_a = (LIN_W + 1)'(r_lin_a) + (LIN_W + 1)'(n_ca);
        n_lin_sum_b = (LIN_W + 1)'(r_lin_b) + (LIN_W + 1)'(n_cb);
        if (n_lin_sum_a[LIN_W] != n_lin_sum_a[LIN_W-1]) begin
            n_lin_a = n_lin_sum_a[LIN_W] ? {1'b1, {(LIN_W-1){1'b0}}}
                                         : {1'b0, {(LIN_W-1){1'b1}}};
        end else begin
            n_lin_a = n_lin_sum_a[LIN_W-1:0];
        end
        if (n_lin_sum_b[LIN_W] != n_lin_sum_b[LIN_W-1]) begin
            n_lin_b = n_lin_sum_b[LIN_W] ? {1'b1, {(LIN_W-1){1'b0}}}
                                         : {1'b0, {(LIN_W-1){1'b1}}};
        end else begin
            n_lin_b = n_lin_sum_b[LIN_W-1:0];
        end
    end

    // saturating window accumulators fed from the multiplier
    always_comb begin
        n_sq_sum = {1'b0, (r_state == S_MP) ? r_sq_b : r_sq_a}
                 + (SQ_W + 1)'(mul_prod[2*ADC_BITS-1:0]);
        n_sq     = n_sq_sum[SQ_W] ? '1 : n_sq_sum[SQ_W-1:0];
        n_ps_sum = (PS_W + 1)'(r_ps) + (PS_W + 1)'(mul_prod);
        if (n_ps_sum[PS_W] != n_ps_sum[PS_W-1]) begin
            n_ps = n_ps_sum[PS_W] ? {1'b1, {(PS_W-1){1'b0}}}
                                  : {1'b0, {(PS_W-1){1'b1}}};
        end else begin
            n_ps = n_ps_sum[PS_W-1:0];
        end
        n_cnt  = {1'b0, r_count} + (WIN_W + 1)'(1);
        n_last = (n_cnt >= {1'b0, n_len});
    end

    // filter and bias arithmetic for the selected channel
    always_comb begin
        filt_sel  = r_ch ? r_filt_b : r_filt_a;
        lin_sel   = r_ch ? r_lin_b  : r_lin_a;
        bias_sel  = r_ch ? r_bias_b : r_bias_a;
        n_w       = (ALPHA_W + 1)'(1 << FRAC_W) - {1'b0, r_alpha};
        n_rnd_sum = r_p + (r_p[PART_W-1] ? RND_DN : RND_UP);
        n_f       = (PROD_W + 1)'(mul_prod) + (PROD_W + 1)'(r_rnd);
        n_k       = FILT_W'(n_len) << (FRAC_W - 1);
        n_x       = filt_sel[FILT_W-1] ? (n_k - filt_sel) : (n_k + filt_sel);
        n_bb      = signed'(BV_W'(bias_sel));
        n_bq      = signed'(BV_W'(div_q));
        n_bv      = filt_sel[FILT_W-1] ? (n_bb - n_bq) : (n_bb + n_bq);
        if (n_bv[BV_W-1]) begin
            n_bias = '0;
        end else if (n_bv > signed'(BV_W'(ADC_MAX))) begin
            n_bias = ADC_MAX;
        end else begin
            n_bias = n_bv[ADC_BITS-1:0];
        end
    end

    // multiplier operand select per sequencer step
    always_comb begin
        mul_start = 1'b0;
        mul_x     = '0;
        mul_y     = '0;
        unique case (r_state)
            S_MA: begin
                mul_start = 1'b1;
                mul_x     = MUL_XW'(r_ca);
                mul_y     = MUL_YW'(r_ca);
            end
            S_MB: begin
                mul_start = 1'b1;
                mul_x     = MUL_XW'(r_cb);
                mul_y     = MUL_YW'(r_cb);
            end
            S_MP: begin
                mul_start = 1'b1;
                mul_x     = MUL_XW'(r_ca);
                mul_y     = MUL_YW'(r_cb);
            end
            S_F0: begin
                mul_start = 1'b1;
                mul_x     = MUL_XW'({1'b0, filt_sel[HALF_W-1:0]});
                mul_y     = MUL_YW'({1'b0, n_w});
            end
            S_F1: begin
                mul_start = 1'b1;
                mul_x     = MUL_XW'(signed'(filt_sel[FILT_W-1:HALF_W]));
                mul_y     = MUL_YW'({1'b0, n_w});
            end
            S_F2: begin
                mul_start = 1'b1;
                mul_x     = MUL_XW'(lin_sel);
                mul_y     = MUL_YW'({1'b0, r_alpha});
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    assign div_start = (r_state == S_F5);

    dcpa_mul u_mul (
        .i_clk   (i_clk),
        .i_start (mul_start),
        .i_x     (mul_x),
        .i_y     (mul_y),
        .o_prod  (mul_prod)
    );

    dcpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (n_x[FRAC_W+DIV_W-1:FRAC_W]),
        .i_divisor  (n_len),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // sequencer, state and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_window    <= WINDOW_RST;
            r_base      <= 1'b1;
            r_single    <= 1'b0;
            r_alpha     <= ALPHA_RST;
            r_acq       <= 1'b0;
            r_count     <= '0;
            r_sq_a      <= '0;
            r_sq_b      <= '0;
            r_ps        <= '0;
            r_lin_a     <= '0;
            r_lin_b     <= '0;
            r_filt_a    <= '0;
            r_filt_b    <= '0;
            r_bias_a    <= BIAS_MID;
            r_bias_b    <= BIAS_MID;
            r_ch        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // register writes
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_WINDOW:   r_window <= i_cfg_data[WIN_W-1:0];
                    REG_BASELINE: r_base   <= i_cfg_data[0];
                    REG_SINGLE:   r_single <= i_cfg_data[0];
                    REG_ALPHA:    r_alpha  <= i_cfg_data[ALPHA_W-1:0];
                endcase
            end

            // output word taken
            if (r_out_valid && !i_out_stall && r_state != S_OUT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_command)
                            CMD_START: r_acq <= 1'b1;
                            CMD_STOP:  r_acq <= 1'b0;
                            CMD_SAMPLE: begin
                                if (r_acq) begin
                                    r_ca <= n_ca;
                                    r_cb <= n_cb;
                                    if (r_base) begin
                                        r_lin_a <= n_lin_a;
                                        r_lin_b <= n_lin_b;
                                    end
                                    r_state <= S_MA;
                                end
                            end
                            CMD_RSVD: r_acq <= r_acq;
                        endcase
                    end
                end
                S_MA: r_state <= S_MB;
                S_MB: begin
                    r_sq_a  <= n_sq;
                    r_state <= S_MP;
                end
                S_MP: begin
                    r_sq_b  <= n_sq;
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_ps    <= n_ps;
                    r_count <= n_cnt[WIN_W-1:0];
                    r_ch    <= 1'b0;
                    if (!n_last) begin
                        r_state <= S_IDLE;
                    end else if (r_base) begin
                        r_state <= S_F0;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_F0: r_state <= S_F1;
                S_F1: begin
                    r_p     <= PART_W'(mul_prod);
                    r_state <= S_F2;
                end
                S_F2: begin
                    r_p     <= r_p + (PART_W'(mul_prod) <<< HALF_W);
                    r_state <= S_F3;
                end
                S_F3: begin
                    r_rnd   <= n_rnd_sum[PART_W-1:FRAC_W];
                    r_state <= S_F4;
                end
                S_F4: begin
                    if (r_ch) begin
                        r_filt_b <= n_f[FILT_W-1:0];
                    end else begin
                        r_filt_a <= n_f[FILT_W-1:0];
                    end
                    r_state <= S_F5;
                end
                S_F5: r_state <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_BIAS;
                    end
                end
                S_BIAS: begin
                    if (r_ch) begin
                        r_bias_b <= n_bias;
                        r_state  <= S_OUT;
                    end else begin
                        r_bias_a <= n_bias;
                        r_ch     <= 1'b1;
                        r_state  <= S_F0;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_sq_a   <= r_sq_a;
                        r_out_sq_b   <= r_sq_b;
                        r_out_ps     <= r_ps;
                        r_out_bias_a <= r_bias_a;
                        r_out_bias_b <= r_bias_b;
                        r_out_done   <= r_single;
                        if (r_single) begin
                            r_acq <= 1'b0;
                        end
                        r_count <= '0;
                        r_sq_a  <= '0;
                        r_sq_b  <= '0;
                        r_ps    <= '0;
                        r_lin_a <= '0;
                        r_lin_b <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_sum_sq_a    = r_out_sq_a;
    assign o_sum_sq_b    = r_out_sq_b;
    assign o_sum_product = r_out_ps;
    assign o_bias_a_out  = r_out_bias_a;
    assign o_bias_b_out  = r_out_bias_b;
    assign o_scan_done   = r_out_done;

endmodule

[sv/dcpa_checker.sv]
module dcpa_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              o_in_stall,
    input logic [1:0]                        i_command,
    input logic                              o_out_valid,
    input logic                              i_out_stall,
    input logic [dcpa_pkg::SQ_W-1:0]         o_sum_sq_a,
    input logic [dcpa_pkg::SQ_W-1:0]         o_sum_sq_b,
    input logic signed [dcpa_pkg::PS_W-1:0]  o_sum_product,
    input logic [dcpa_pkg::ADC_BITS-1:0]     o_bias_a_out,
    input logic [dcpa_pkg::ADC_BITS-1:0]     o_bias_b_out,
    input logic                              o_scan_done
);
    import dcpa_pkg::*;

    // reset leaves no word pending and the input open
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output word or input stall present after reset");

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_sum_sq_a)
            && $stable(o_sum_sq_b) && $stable(o_sum_product)
            && $stable(o_bias_a_out) && $stable(o_bias_b_out) && $stable(o_scan_done))
        else $error("stalled output word changed");

    // start, stop and reserved commands finish in their own cycle
    a_cmd_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_command != CMD_SAMPLE |=> !o_in_stall)
        else $error("command kept the input stalled");

    // a new word only appears at the end of work on a sample pair
    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("output word appeared without work in progress");

    // a silent first channel gives a zero product sum
    a_zero_product: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sum_sq_a == '0 |-> o_sum_product == '0)
        else $error("nonzero product sum with zero first-channel energy");

endmodule

bind dual_channel_power_accumulator dcpa_checker u_dcpa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_stall    (o_in_stall),
    .i_command     (i_command),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_sum_sq_a    (o_sum_sq_a),
    .o_sum_sq_b    (o_sum_sq_b),
    .o_sum_product (o_sum_product),
    .o_bias_a_out  (o_bias_a_out),
    .o_bias_b_out  (o_bias_b_out),
    .o_scan_done   (o_scan_done)
);
